// ----- rtl/lap_pkg.sv -----
// Shared widths, types and constants of the largest-remainder apportionment core.
package lap_pkg;

    localparam int SLOTS         = 7;
    localparam int FALLBACK_SLOT = 5;
    localparam int IN_W          = 32;
    localparam int VAL_W         = 31;
    localparam int SUM_W         = 34;
    localparam int PROD_W        = 2 * VAL_W;
    localparam int DIV_STAGES    = VAL_W;
    localparam int RANK_W        = 3;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [RANK_W-1:0] rank_t;

    typedef struct packed {
        val_t total;
        logic tpos;
        sum_t sum;
    } meta_t;

endpackage

// ----- rtl/lap_lane.sv -----
// One lane: weight times total, then a restoring divider with one quotient bit per stage.
module lap_lane (
    input  logic                clk,
    input  logic                en,
    input  lap_pkg::val_t       weight,
    input  lap_pkg::val_t       total,
    input  lap_pkg::sum_t       sums [lap_pkg::DIV_STAGES],
    output lap_pkg::val_t       quotient,
    output lap_pkg::sum_t       remainder
);

    localparam int VW = lap_pkg::VAL_W;
    localparam int SW = lap_pkg::SUM_W;
    localparam int PW = lap_pkg::PROD_W;
    localparam int DS = lap_pkg::DIV_STAGES;

    logic [PW-1:0] num_reg;
    lap_pkg::sum_t r_reg  [DS];
    lap_pkg::val_t qd_reg [DS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= weight * total;
        end
    end

    for (genvar k = 0; k < DS; k++)
    begin : g_stage
        lap_pkg::sum_t r_cur;
        lap_pkg::val_t qd_cur;
        logic [SW:0]   r2;
        logic [SW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_cur  = {{(SW-VW){1'b0}}, num_reg[PW-1:VW]};
            assign qd_cur = num_reg[VW-1:0];
        end
        else
        begin : g_next
            assign r_cur  = r_reg[k-1];
            assign qd_cur = qd_reg[k-1];
        end

        assign r2   = {r_cur, qd_cur[VW-1]};
        assign ge   = (r2 >= {1'b0, sums[k]});
        assign diff = r2 - {1'b0, sums[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]  <= ge ? diff[SW-1:0] : r2[SW-1:0];
                qd_reg[k] <= {qd_cur[VW-2:0], ge};
            end
        end
    end

    assign quotient  = qd_reg[DS-1];
    assign remainder = r_reg[DS-1];

endmodule

// ----- rtl/lap_merge.sv -----
// Merge stage: ranks remainders, hands out leftover units, holds the output register.
module lap_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                load,
    input  logic                in_valid,
    input  lap_pkg::val_t       quot [lap_pkg::SLOTS],
    input  lap_pkg::sum_t       rem  [lap_pkg::SLOTS],
    input  lap_pkg::meta_t      meta,
    output lap_pkg::val_t       share [lap_pkg::SLOTS],
    output logic                result_valid,
    output logic                out_valid,
    output logic                m1_valid
);

    localparam int N  = lap_pkg::SLOTS;
    localparam int VW = lap_pkg::VAL_W;
    localparam int SW = lap_pkg::SUM_W;

    logic           m1_valid_reg;
    lap_pkg::val_t  q_reg    [N];
    lap_pkg::rank_t rank_reg [N];
    lap_pkg::sum_t  assigned_reg;
    lap_pkg::meta_t meta_reg;

    lap_pkg::rank_t rank_c [N];
    lap_pkg::sum_t  assigned_c;

    always_comb
    begin
        assigned_c = '0;
        for (int i = 0; i < N; i++)
        begin
            assigned_c = assigned_c + {{(SW-VW){1'b0}}, quot[i]};
            rank_c[i]  = '0;
            for (int k = 0; k < N; k++)
            begin
                if ((rem[k] > rem[i]) || ((rem[k] == rem[i]) && (k < i)))
                begin
                    rank_c[i] = rank_c[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg        <= quot;
            rank_reg     <= rank_c;
            assigned_reg <= assigned_c;
            meta_reg     <= meta;
        end
    end

    // leftover never exceeds six units
    lap_pkg::sum_t  left_full;
    lap_pkg::rank_t left;
    lap_pkg::val_t  share_next [N];
    logic           sum_zero;

    assign left_full = {{(SW-VW){1'b0}}, meta_reg.total} - assigned_reg;
    assign left      = left_full[lap_pkg::RANK_W-1:0];
    assign sum_zero  = (meta_reg.sum == '0);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (!meta_reg.tpos)
            begin
                share_next[i] = '0;
            end
            else if (sum_zero)
            begin
                share_next[i] = (i == lap_pkg::FALLBACK_SLOT) ? meta_reg.total : '0;
            end
            else
            begin
                share_next[i] = q_reg[i] + {{(VW-1){1'b0}}, (rank_reg[i] < left)};
            end
        end
    end

    logic          out_valid_reg;
    logic          result_valid_reg;
    lap_pkg::val_t share_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            share_reg        <= share_next;
            result_valid_reg <= meta_reg.tpos;
        end
    end

    assign share        = share_reg;
    assign result_valid = result_valid_reg;
    assign out_valid    = out_valid_reg;
    assign m1_valid     = m1_valid_reg;

endmodule

// ----- rtl/largest_remainder_apportion_core.sv -----
// Top level of the largest-remainder apportionment core.
// Usage:
//   Input transaction: weight_0..weight_6 and target_total on in_valid/in_ready.
//   Output transaction: share_0..share_6 and result_valid on out_valid/out_ready.
//   Each slot gets floor(w*T/S) from its own lane; the leftover units (at most
//   six) go to the slots with the largest remainders, lower index first.
// Pipeline: input register at the accepting edge, then multiply, 31 divider
//   stages, rank stage and output register, which drives out_valid.
// Throughput: one transaction per cycle while in_ready is high; the dividers
//   are pipelined one bit per stage, each stage one 35-bit subtract and compare.
// Reset: rst_n clears all valid flags but result_valid; the pipeline is empty after reset.
// Stall: while a result waits at the output, the pipeline keeps moving until
//   a finished transaction reaches the rank stage; only then does it hold and
//   in_ready drops.
module largest_remainder_apportion_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] weight_0,
    input  logic [31:0] weight_1,
    input  logic [31:0] weight_2,
    input  logic [31:0] weight_3,
    input  logic [31:0] weight_4,
    input  logic [31:0] weight_5,
    input  logic [31:0] weight_6,
    input  logic [31:0] target_total,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] share_0,
    output logic [30:0] share_1,
    output logic [30:0] share_2,
    output logic [30:0] share_3,
    output logic [30:0] share_4,
    output logic [30:0] share_5,
    output logic [30:0] share_6,
    output logic        result_valid
);

    localparam int N  = lap_pkg::SLOTS;
    localparam int DS = lap_pkg::DIV_STAGES;
    localparam int VW = lap_pkg::VAL_W;
    localparam int SW = lap_pkg::SUM_W;
    localparam int IW = lap_pkg::IN_W;

    logic out_free;
    logic m1_valid;
    logic en;

    assign out_free = !out_valid || out_ready;
    assign en       = out_free || !m1_valid;
    assign in_ready = en;

    logic [IW-1:0] w_in [N];
    assign w_in[0] = weight_0;
    assign w_in[1] = weight_1;
    assign w_in[2] = weight_2;
    assign w_in[3] = weight_3;
    assign w_in[4] = weight_4;
    assign w_in[5] = weight_5;
    assign w_in[6] = weight_6;

    // input register, negative weights clamped
    logic          s0_valid_reg;
    lap_pkg::val_t w_reg [N];
    lap_pkg::val_t t_reg;
    logic          tpos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                w_reg[i] <= w_in[i][IW-1] ? '0 : w_in[i][VW-1:0];
            end
            t_reg    <= target_total[VW-1:0];
            tpos_reg <= !target_total[IW-1] && (target_total != '0);
        end
    end

    lap_pkg::sum_t sum_c;

    always_comb
    begin
        sum_c = '0;
        for (int i = 0; i < N; i++)
        begin
            sum_c = sum_c + {{(SW-VW){1'b0}}, w_reg[i]};
        end
    end

    // side pipeline alongside the lanes
    logic           v_pipe    [DS+1];
    lap_pkg::meta_t meta_pipe [DS+1];
    lap_pkg::sum_t  sums      [DS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DS; k++)
            begin
                v_pipe[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_pipe[0] <= s0_valid_reg;
            for (int k = 1; k <= DS; k++)
            begin
                v_pipe[k] <= v_pipe[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_pipe[0] <= '{total: t_reg, tpos: tpos_reg, sum: sum_c};
            for (int k = 1; k <= DS; k++)
            begin
                meta_pipe[k] <= meta_pipe[k-1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < DS; k++)
        begin
            sums[k] = meta_pipe[k].sum;
        end
    end

    lap_pkg::val_t quot [N];
    lap_pkg::sum_t rem  [N];

    for (genvar i = 0; i < N; i++)
    begin : g_lane
        lap_lane u_lane (
            .clk       (clk),
            .en        (en),
            .weight    (w_reg[i]),
            .total     (t_reg),
            .sums      (sums),
            .quotient  (quot[i]),
            .remainder (rem[i])
        );
    end

    lap_pkg::val_t share [N];

    lap_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .load         (out_free),
        .in_valid     (v_pipe[DS]),
        .quot         (quot),
        .rem          (rem),
        .meta         (meta_pipe[DS]),
        .share        (share),
        .result_valid (result_valid),
        .out_valid    (out_valid),
        .m1_valid     (m1_valid)
    );

    assign share_0 = share[0];
    assign share_1 = share[1];
    assign share_2 = share[2];
    assign share_3 = share[3];
    assign share_4 = share[4];
    assign share_5 = share[5];
    assign share_6 = share[6];

`ifndef SYNTH
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_valid) |-> ((share_0 | share_1 | share_2 | share_3 |
                                           share_4 | share_5 | share_6) == '0))
        else $error("shares nonzero with result_valid clear");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v_pipe[DS]) && $stable(s0_valid_reg) && $stable(m1_valid)))
        else $error("pipeline moved while stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s0_valid_reg)
        else $error("accepted transaction lost at input register");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> (out_valid && !out_ready && m1_valid))
        else $error("stall without a blocked result");
`endif

endmodule
